// ===== rtl/dccs_pkg.sv =====
// Shared types and constants for the DER certificate chain splitter.
`default_nettype none

package dccs_pkg;

    localparam logic [7:0] TAG_SEQUENCE      = 8'h30;
    localparam int         LONG_FORM_BIT     = 7;
    localparam logic [6:0] LENGTH_COUNT_MASK = 7'h7F;
    localparam int         BYTE_W            = 8;

    typedef enum logic [1:0] {
        PH_TAG      = 2'd0,
        PH_LEN      = 2'd1,
        PH_LENBYTES = 2'd2,
        PH_BODY     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_TAG = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_BEYOND  = 2'd3
    } status_t;

    typedef struct packed {
        logic    cert_first;
        logic    cert_last;
        status_t status;
    } flags_t;

endpackage

`default_nettype wire

// ===== rtl/dccs_parse.sv =====
// Header parser state and per-item step logic.
`default_nettype none

module dccs_parse #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int CERT_INDEX_BITS  = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        enable,
    input  wire logic [7:0]                  in_byte,
    input  wire logic                        in_last,
    output logic [CERT_INDEX_BITS-1:0]       cert_number,
    output dccs_pkg::flags_t                 flags
);

    localparam int BODY_W    = MAX_LENGTH_BYTES * dccs_pkg::BYTE_W;
    localparam int LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);
    localparam logic [CERT_INDEX_BITS-1:0] CERT_MAX = {CERT_INDEX_BITS{1'b1}};

    dccs_pkg::phase_t            phase_reg, phase_next;
    logic [LEN_CNT_W-1:0]        left_reg, left_next;
    logic [BODY_W-1:0]           body_reg, body_next;
    logic [CERT_INDEX_BITS-1:0]  count_reg, count_next;
    dccs_pkg::status_t           error_reg, error_next;

    logic                        finish;
    dccs_pkg::status_t           status_step;
    logic [6:0]                  len_count;
    logic [BODY_W-1:0]           body_shift;
    logic [BODY_W-1:0]           body_dec;
    logic [LEN_CNT_W-1:0]        left_dec;

    assign len_count  = in_byte[6:0] & dccs_pkg::LENGTH_COUNT_MASK;
    assign body_shift = BODY_W'({body_reg, in_byte});
    assign body_dec   = body_reg - 1'b1;
    assign left_dec   = left_reg - 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        body_next   = body_reg;
        count_next  = count_reg;
        error_next  = error_reg;
        finish      = 1'b0;
        if (error_reg == dccs_pkg::ST_OK)
        begin
            unique case (phase_reg)
                dccs_pkg::PH_TAG:
                begin
                    if (in_byte != dccs_pkg::TAG_SEQUENCE)
                        error_next = dccs_pkg::ST_BAD_TAG;
                    else
                        phase_next = dccs_pkg::PH_LEN;
                end
                dccs_pkg::PH_LEN:
                begin
                    if (in_byte[dccs_pkg::LONG_FORM_BIT])
                    begin
                        if (len_count > 7'(MAX_LENGTH_BYTES))
                            error_next = dccs_pkg::ST_BAD_LEN;
                        else if (len_count == 7'd0)
                            finish = 1'b1;
                        else
                        begin
                            left_next  = len_count[LEN_CNT_W-1:0];
                            body_next  = '0;
                            phase_next = dccs_pkg::PH_LENBYTES;
                        end
                    end
                    else if (in_byte == 8'd0)
                        finish = 1'b1;
                    else
                    begin
                        body_next  = BODY_W'(in_byte);
                        phase_next = dccs_pkg::PH_BODY;
                    end
                end
                dccs_pkg::PH_LENBYTES:
                begin
                    body_next = body_shift;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        if (body_shift == '0)
                            finish = 1'b1;
                        else
                            phase_next = dccs_pkg::PH_BODY;
                    end
                end
                dccs_pkg::PH_BODY:
                begin
                    body_next = body_dec;
                    if (body_dec == '0)
                        finish = 1'b1;
                end
                default:
                begin
                    phase_next = dccs_pkg::PH_TAG;
                end
            endcase
        end

        if (finish)
        begin
            phase_next = dccs_pkg::PH_TAG;
            body_next  = '0;
            left_next  = '0;
            if (count_reg != CERT_MAX)
                count_next = count_reg + 1'b1;
        end

        if (in_last && error_next == dccs_pkg::ST_OK)
        begin
            if (phase_next == dccs_pkg::PH_LEN || phase_next == dccs_pkg::PH_LENBYTES)
                error_next = dccs_pkg::ST_BAD_LEN;
            else if (phase_next == dccs_pkg::PH_BODY)
                error_next = dccs_pkg::ST_BEYOND;
        end
        status_step = error_next;

        if (in_last)
        begin
            phase_next = dccs_pkg::PH_TAG;
            left_next  = '0;
            body_next  = '0;
            count_next = '0;
            error_next = dccs_pkg::ST_OK;
        end
    end

    always_comb
    begin
        cert_number      = count_reg;
        flags.cert_first = (error_reg == dccs_pkg::ST_OK) && (phase_reg == dccs_pkg::PH_TAG);
        flags.cert_last  = finish;
        flags.status     = status_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dccs_pkg::PH_TAG;
            left_reg  <= '0;
            body_reg  <= '0;
            count_reg <= '0;
            error_reg <= dccs_pkg::ST_OK;
        end
        else if (enable)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            body_reg  <= body_next;
            count_reg <= count_next;
            error_reg <= error_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/der_certificate_chain_splitter_unit.sv =====
// Top level of the DER certificate chain splitter: input and result registers around the parser.
// Path: input register, then the parser step, then the result register.
// Throughput: one item per cycle; the parser state advances once per item in a single pass.
// Back-pressure from m_axis_tready stalls the input register and the parser together.
// Reset: rst_n asynchronous, active low; clears valid flags, parser state and error status.
`default_nettype none

module der_certificate_chain_splitter_unit #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int CERT_INDEX_BITS  = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] chain_byte
    input  wire logic                  s_axis_tlast,   // chain_last
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [((CERT_INDEX_BITS + 17) / 8) * 8 - 1:0] m_axis_tdata,
                                       // out_byte, cert_number, status, zero fill
    output logic [1:0]                 m_axis_tuser,   // cert_first, cert_last
    output logic                       m_axis_tlast    // chain_done
);

    localparam int PACK_W   = dccs_pkg::BYTE_W + CERT_INDEX_BITS + 2;
    localparam int M_DATA_W = ((PACK_W + 7) / 8) * 8;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_last_reg;

    logic                        out_valid_reg;
    logic [7:0]                  out_byte_reg;
    logic [CERT_INDEX_BITS-1:0]  out_number_reg;
    dccs_pkg::flags_t            out_flags_reg;
    logic                        out_done_reg;

    logic                        advance;
    logic                        process;
    logic [CERT_INDEX_BITS-1:0]  cert_number;
    dccs_pkg::flags_t            flags;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    dccs_parse #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .CERT_INDEX_BITS  (CERT_INDEX_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (process),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .cert_number (cert_number),
        .flags       (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (process)
        begin
            out_byte_reg   <= in_byte_reg;
            out_number_reg <= cert_number;
            out_flags_reg  <= flags;
            out_done_reg   <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'({out_flags_reg.status, out_number_reg, out_byte_reg});
    assign m_axis_tuser  = {out_flags_reg.cert_last, out_flags_reg.cert_first};
    assign m_axis_tlast  = out_done_reg;

endmodule

`default_nettype wire

// ===== test/tb_der_certificate_chain_splitter_unit.sv =====
// Testbench for the DER cert chain splitter: table-driven and random chains, checked by table or predictor.
module tb_der_certificate_chain_splitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CIDX_W     = 4;
    localparam int          MAX_LB     = 4;
    localparam int          TD_W       = ((CIDX_W + 17) / 8) * 8;
    localparam logic [3:0]  CERT_SAT   = 4'hF;
    localparam int          RAND_ITEMS = 575;
    localparam int unsigned LIMIT      = 200000;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic [3:0]        cert_number;
        logic              cert_first;
        logic              cert_last;
        logic              chain_done;
        dccs_pkg::status_t status;
    } tagged_byte_t;

    typedef struct {
        logic [7:0]   b;
        logic         l;
        bit           typed;
        tagged_byte_t r;
    } stim_row_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
    } chain_item_t;

    localparam tagged_byte_t NO_RES = '{8'h00, 4'd0, 1'b0, 1'b0, 1'b0, dccs_pkg::ST_OK};

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata  = 8'h00;
    logic            s_axis_tlast  = 1'b0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [TD_W-1:0] m_axis_tdata;
    logic [1:0]      m_axis_tuser;
    logic            m_axis_tlast;

    dccs_pkg::phase_t  chain_phase = dccs_pkg::PH_TAG;
    logic [2:0]        len_left    = 3'd0;
    logic [31:0]       body_left   = 32'd0;
    logic [3:0]        cert_cnt    = 4'd0;
    dccs_pkg::status_t chain_err   = dccs_pkg::ST_OK;

    tagged_byte_t tagged_q[$];
    stim_row_t    dir_tab[$];
    chain_item_t  chain_q[$];

    int unsigned bad_cnt   = 0;
    int unsigned sent      = 0;
    int unsigned cycle_cnt = 0;
    bit          tx_burst  = 1'b0;
    bit          rx_burst  = 1'b0;
    logic        rx_hold   = 1'b0;

    der_certificate_chain_splitter_unit #(
        .MAX_LENGTH_BYTES (MAX_LB),
        .CERT_INDEX_BITS  (CIDX_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic tag_byte(input logic [7:0] b, input logic l, output tagged_byte_t r);
        bit closed;
        closed        = 1'b0;
        r.out_byte    = b;
        r.cert_number = cert_cnt;
        r.cert_first  = 1'b0;
        r.cert_last   = 1'b0;
        if (chain_err == dccs_pkg::ST_OK)
        begin
            case (chain_phase)
                dccs_pkg::PH_TAG:
                begin
                    r.cert_first = 1'b1;
                    if (b != dccs_pkg::TAG_SEQUENCE)
                        chain_err = dccs_pkg::ST_BAD_TAG;
                    else
                        chain_phase = dccs_pkg::PH_LEN;
                end
                dccs_pkg::PH_LEN:
                begin
                    if (b[dccs_pkg::LONG_FORM_BIT])
                    begin
                        if ((b[6:0] & dccs_pkg::LENGTH_COUNT_MASK) > MAX_LB)
                            chain_err = dccs_pkg::ST_BAD_LEN;
                        else if (b[6:0] == 7'd0)
                            closed = 1'b1;
                        else
                        begin
                            len_left    = b[2:0];
                            body_left   = 32'd0;
                            chain_phase = dccs_pkg::PH_LENBYTES;
                        end
                    end
                    else if (b == 8'h00)
                        closed = 1'b1;
                    else
                    begin
                        body_left   = {24'd0, b};
                        chain_phase = dccs_pkg::PH_BODY;
                    end
                end
                dccs_pkg::PH_LENBYTES:
                begin
                    body_left = {body_left[23:0], b};
                    len_left  = len_left - 3'd1;
                    if (len_left == 3'd0)
                    begin
                        if (body_left == 32'd0)
                            closed = 1'b1;
                        else
                            chain_phase = dccs_pkg::PH_BODY;
                    end
                end
                default:
                begin
                    body_left = body_left - 32'd1;
                    if (body_left == 32'd0)
                        closed = 1'b1;
                end
            endcase
        end
        if (closed)
        begin
            r.cert_last = 1'b1;
            chain_phase = dccs_pkg::PH_TAG;
            body_left   = 32'd0;
            len_left    = 3'd0;
            if (cert_cnt != CERT_SAT)
                cert_cnt = cert_cnt + 4'd1;
        end
        if (l && chain_err == dccs_pkg::ST_OK)
        begin
            if (chain_phase == dccs_pkg::PH_LEN || chain_phase == dccs_pkg::PH_LENBYTES)
                chain_err = dccs_pkg::ST_BAD_LEN;
            else if (chain_phase == dccs_pkg::PH_BODY)
                chain_err = dccs_pkg::ST_BEYOND;
        end
        r.status     = chain_err;
        r.chain_done = l;
        if (l)
        begin
            chain_phase = dccs_pkg::PH_TAG;
            len_left    = 3'd0;
            body_left   = 32'd0;
            cert_cnt    = 4'd0;
            chain_err   = dccs_pkg::ST_OK;
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic l, input bit typed,
                           input tagged_byte_t r);
        stim_row_t row;
        row.b     = b;
        row.l     = l;
        row.typed = typed;
        row.r     = r;
        dir_tab.insert(dir_tab.size(), row);
    endtask

    task automatic put_byte(input logic [7:0] b);
        chain_item_t it;
        it.b = b;
        it.l = 1'b0;
        chain_q.insert(chain_q.size(), it);
    endtask

    // hold the item until accepted, then record what it should produce
    task automatic offer(input logic [7:0] b, input logic l, input bit typed,
                         input tagged_byte_t tr);
        int           gap;
        tagged_byte_t pr;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do @(posedge clk); while (!s_axis_tready);
        tag_byte(b, l, pr);
        tagged_q.insert(tagged_q.size(), typed ? tr : pr);
        sent++;
    endtask

    task automatic add_cert(input int body_len);
        int nmin;
        int n;
        put_byte(dccs_pkg::TAG_SEQUENCE);
        if (body_len < 128 && $urandom_range(0, 2) != 0)
            put_byte(body_len[7:0]);
        else
        begin
            nmin = (body_len == 0) ? 0 : (body_len < 256) ? 1 : (body_len < 65536) ? 2 : 3;
            n    = $urandom_range(nmin, MAX_LB);
            put_byte(8'h80 | n[7:0]);
            for (int i = n - 1; i >= 0; i--)
                put_byte(8'((body_len >> (8 * i)) & 'hFF));
        end
        for (int i = 0; i < body_len; i++)
            put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_chain();
        int          start;
        int          kind;
        int          ncert;
        int          cut;
        int          n;
        logic [7:0]  b;
        start = chain_q.size();
        kind  = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            ncert = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
            repeat (ncert)
                add_cert(($urandom_range(0, 15) == 0) ? $urandom_range(128, 300)
                                                      : $urandom_range(0, 12));
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(1, 3)) add_cert($urandom_range(0, 12));
            if ($urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, MAX_LB);
                put_byte(dccs_pkg::TAG_SEQUENCE);
                put_byte(8'h80 | n[7:0]);
                repeat (n) put_byte(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 6))
                    put_byte(8'($urandom_range(0, 255)));
            end
            cut = $urandom_range(start + 1, chain_q.size());
            while (chain_q.size() > cut)
                void'(chain_q.pop_back());
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(0, 2)) add_cert($urandom_range(0, 12));
            if ($urandom_range(0, 1) == 1)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == dccs_pkg::TAG_SEQUENCE)
                    b = 8'h31;
                put_byte(b);
            end
            else
            begin
                put_byte(dccs_pkg::TAG_SEQUENCE);
                put_byte(8'h80 | 8'($urandom_range(MAX_LB + 1, 127)));
            end
            repeat ($urandom_range(0, 5))
                put_byte(8'($urandom_range(0, 255)));
        end
        else
            repeat ($urandom_range(1, 8))
                put_byte(8'($urandom_range(0, 255)));
        chain_q[chain_q.size() - 1].l = 1'b1;
    endtask

    initial
    begin
        int unsigned rnd_start;
        add_row(8'h30, 1'b0, 1'b1, '{8'h30, 4'd0, 1'b1, 1'b0, 1'b0, dccs_pkg::ST_OK});
        add_row(8'h00, 1'b0, 1'b1, '{8'h00, 4'd0, 1'b0, 1'b1, 1'b0, dccs_pkg::ST_OK});
        add_row(8'h30, 1'b0, 1'b0, NO_RES);
        add_row(8'h80, 1'b0, 1'b1, '{8'h80, 4'd1, 1'b0, 1'b1, 1'b0, dccs_pkg::ST_OK});
        add_row(8'h30, 1'b0, 1'b0, NO_RES);
        add_row(8'h84, 1'b0, 1'b0, NO_RES);
        add_row(8'h00, 1'b0, 1'b0, NO_RES);
        add_row(8'h00, 1'b0, 1'b0, NO_RES);
        add_row(8'h00, 1'b0, 1'b0, NO_RES);
        add_row(8'h01, 1'b0, 1'b0, NO_RES);
        add_row(8'hFF, 1'b0, 1'b1, '{8'hFF, 4'd2, 1'b0, 1'b1, 1'b0, dccs_pkg::ST_OK});
        add_row(8'h30, 1'b0, 1'b0, NO_RES);
        add_row(8'h81, 1'b0, 1'b0, NO_RES);
        add_row(8'h00, 1'b0, 1'b1, '{8'h00, 4'd3, 1'b0, 1'b1, 1'b0, dccs_pkg::ST_OK});
        add_row(8'h30, 1'b0, 1'b0, NO_RES);
        add_row(8'h05, 1'b0, 1'b0, NO_RES);
        add_row(8'hAA, 1'b1, 1'b1, '{8'hAA, 4'd4, 1'b0, 1'b0, 1'b1, dccs_pkg::ST_BEYOND});
        add_row(8'h31, 1'b0, 1'b1, '{8'h31, 4'd0, 1'b1, 1'b0, 1'b0, dccs_pkg::ST_BAD_TAG});
        add_row(8'h00, 1'b1, 1'b1, '{8'h00, 4'd0, 1'b0, 1'b0, 1'b1, dccs_pkg::ST_BAD_TAG});
        add_row(8'h30, 1'b0, 1'b0, NO_RES);
        add_row(8'h85, 1'b1, 1'b1, '{8'h85, 4'd0, 1'b0, 1'b0, 1'b1, dccs_pkg::ST_BAD_LEN});
        add_row(8'h30, 1'b1, 1'b1, '{8'h30, 4'd0, 1'b1, 1'b0, 1'b1, dccs_pkg::ST_BAD_LEN});
        add_row(8'h30, 1'b0, 1'b0, NO_RES);
        add_row(8'h82, 1'b0, 1'b0, NO_RES);
        add_row(8'h01, 1'b1, 1'b1, '{8'h01, 4'd0, 1'b0, 1'b0, 1'b1, dccs_pkg::ST_BAD_LEN});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            offer(dir_tab[i].b, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].r);

        rnd_start = sent;
        while (sent - rnd_start < RAND_ITEMS)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            build_chain();
            foreach (chain_q[i])
            begin
                if (sent - rnd_start + 1 >= RAND_ITEMS)
                    chain_q[i].l = 1'b1;
                offer(chain_q[i].b, chain_q[i].l, 1'b0, NO_RES);
                if (sent - rnd_start >= RAND_ITEMS)
                    break;
            end
            chain_q.delete();
        end
        s_axis_tvalid <= 1'b0;

        while (tagged_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (bad_cnt == 0)
            $display("tb_der_certificate_chain_splitter_unit OK");
        else
            $display("tb_der_certificate_chain_splitter_unit NOT OK");
        $finish;
    end

    initial
    begin
        int gap;
        int k;
        k = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (k % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            k++;
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (gap != 0 || rx_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // stall the output for a long stretch so the input backs up
    initial
    begin
        wait (sent >= 300);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (200) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        tagged_byte_t    w;
        logic [TD_W-1:0] wd;
        logic [1:0]      wu;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tagged_q.size() == 0)
            begin
                bad_cnt++;
                if (bad_cnt <= 10)
                    $display("mismatch: item with none pending, tdata %h tuser %b tlast %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                w  = tagged_q.pop_front();
                wd = {{(TD_W - 14){1'b0}}, w.status, w.cert_number, w.out_byte};
                wu = {w.cert_last, w.cert_first};
                if (m_axis_tdata !== wd || m_axis_tuser !== wu || m_axis_tlast !== w.chain_done)
                begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display({"mismatch: exp byte %h num %0d first %b last %b done %b",
                                  " st %0d, got tdata %h tuser %b tlast %b"},
                                 w.out_byte, w.cert_number, w.cert_first, w.cert_last,
                                 w.chain_done, w.status, m_axis_tdata, m_axis_tuser,
                                 m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_der_certificate_chain_splitter_unit NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dccs_pkg.sv
rtl/dccs_parse.sv
rtl/der_certificate_chain_splitter_unit.sv
test/tb_der_certificate_chain_splitter_unit.sv
